// ===== src/lmst_pkg.sv =====
// shared types and constants for the lcd mode and scanline timer
package lmst_pkg;

  // mode codes as seen on the mode output
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam int DOT_W  = 10;
  localparam int LINE_W = 8;
  localparam int ELAP_W = 8;

  // mode lengths in dots
  localparam logic [DOT_W-1:0] LEN_OAM    = 10'd80;
  localparam logic [DOT_W-1:0] LEN_XFER   = 10'd172;
  localparam logic [DOT_W-1:0] LEN_HBLANK = 10'd204;
  localparam logic [DOT_W-1:0] LEN_LINE   = 10'd456;
  localparam logic [DOT_W-1:0] DOT_MAX    = 10'd1023;

  localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

  // register file
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DISPLAY_ENABLE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COMPARE_LINE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HBLANK_INT_ENABLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VBLANK_INT_ENABLE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OAM_INT_ENABLE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_INT_ENABLE  = 3'd5;

  typedef struct packed {
    logic              display_enable;
    logic [LINE_W-1:0] compare_line;
    logic              hblank_int_enable;
    logic              vblank_int_enable;
    logic              oam_int_enable;
    logic              match_int_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              render_strobe;
    logic              vblank_irq;
    logic              stat_irq;
  } result_t;

endpackage

// ===== src/lmst_cfg.sv =====
// configuration register file behind the apb-style port
module lmst_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmst_pkg::PADDR_W-1:0]  paddr,
  input  logic [lmst_pkg::PDATA_W-1:0]  pwdata,
  output logic [lmst_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output lmst_pkg::cfg_t                cfg
);

  logic                               wr_en;
  logic [lmst_pkg::REG_IDX_W-1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[lmst_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        lmst_pkg::REG_DISPLAY_ENABLE:    cfg.display_enable    <= pwdata[0];
        lmst_pkg::REG_COMPARE_LINE:      cfg.compare_line      <= pwdata[lmst_pkg::LINE_W-1:0];
        lmst_pkg::REG_HBLANK_INT_ENABLE: cfg.hblank_int_enable <= pwdata[0];
        lmst_pkg::REG_VBLANK_INT_ENABLE: cfg.vblank_int_enable <= pwdata[0];
        lmst_pkg::REG_OAM_INT_ENABLE:    cfg.oam_int_enable    <= pwdata[0];
        lmst_pkg::REG_MATCH_INT_ENABLE:  cfg.match_int_enable  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      lmst_pkg::REG_DISPLAY_ENABLE:    prdata[0] = cfg.display_enable;
      lmst_pkg::REG_COMPARE_LINE:      prdata[lmst_pkg::LINE_W-1:0] = cfg.compare_line;
      lmst_pkg::REG_HBLANK_INT_ENABLE: prdata[0] = cfg.hblank_int_enable;
      lmst_pkg::REG_VBLANK_INT_ENABLE: prdata[0] = cfg.vblank_int_enable;
      lmst_pkg::REG_OAM_INT_ENABLE:    prdata[0] = cfg.oam_int_enable;
      lmst_pkg::REG_MATCH_INT_ENABLE:  prdata[0] = cfg.match_int_enable;
      default:                         prdata = '0;
    endcase
  end

endmodule

// ===== src/lmst_step.sv =====
// timing state (mode, line, dot counter) and its per-item update
module lmst_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  logic [lmst_pkg::ELAP_W-1:0] elapsed,
  input  lmst_pkg::cfg_t              cfg,
  output lmst_pkg::result_t           result
);

  logic [1:0]                  mode_reg, mode_next;
  logic [lmst_pkg::LINE_W-1:0] line_reg, line_next;
  logic [lmst_pkg::DOT_W-1:0]  dot_count, dot_next;

  logic [lmst_pkg::DOT_W:0]    dot_sum;
  logic [lmst_pkg::DOT_W-1:0]  dot_sat;
  logic [lmst_pkg::DOT_W-1:0]  len;
  logic                        reached;
  logic [lmst_pkg::LINE_W-1:0] line_inc;
  logic                        render, vblank, stat;

  // saturating dot accumulate
  assign dot_sum = {1'b0, dot_count} + {{(lmst_pkg::DOT_W+1-lmst_pkg::ELAP_W){1'b0}}, elapsed};
  assign dot_sat = dot_sum[lmst_pkg::DOT_W] ? lmst_pkg::DOT_MAX
                                            : dot_sum[lmst_pkg::DOT_W-1:0];
  assign line_inc = line_reg + 8'd1;

  always_comb begin
    case (mode_reg)
      lmst_pkg::MODE_OAM:    len = lmst_pkg::LEN_OAM;
      lmst_pkg::MODE_XFER:   len = lmst_pkg::LEN_XFER;
      lmst_pkg::MODE_HBLANK: len = lmst_pkg::LEN_HBLANK;
      default:               len = lmst_pkg::LEN_LINE;
    endcase
  end

  assign reached = (dot_sat >= len);

  always_comb begin
    mode_next = mode_reg;
    line_next = line_reg;
    dot_next  = reached ? (dot_sat - len) : dot_sat;
    render    = 1'b0;
    vblank    = 1'b0;
    stat      = 1'b0;
    if (reached) begin
      case (mode_reg)
        lmst_pkg::MODE_OAM: begin
          mode_next = lmst_pkg::MODE_XFER;
        end
        lmst_pkg::MODE_XFER: begin
          mode_next = lmst_pkg::MODE_HBLANK;
          render    = cfg.display_enable;
          stat      = cfg.hblank_int_enable;
        end
        lmst_pkg::MODE_HBLANK: begin
          line_next = line_inc;
          if (line_inc == lmst_pkg::FIRST_VBLANK_LINE) begin
            mode_next = lmst_pkg::MODE_VBLANK;
            vblank    = 1'b1;
            stat      = cfg.vblank_int_enable;
          end else begin
            mode_next = lmst_pkg::MODE_OAM;
            stat      = cfg.oam_int_enable ||
                        (cfg.match_int_enable && (line_inc == cfg.compare_line));
          end
        end
        default: begin
          // one vblank line done; wrap to the top after the last line
          if (line_inc > lmst_pkg::LAST_LINE) begin
            mode_next = lmst_pkg::MODE_OAM;
            line_next = '0;
          end else begin
            line_next = line_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg  <= lmst_pkg::MODE_HBLANK;
      line_reg  <= '0;
      dot_count <= '0;
    end else if (step_en) begin
      mode_reg  <= mode_next;
      line_reg  <= line_next;
      dot_count <= dot_next;
    end
  end

  always_comb begin
    result.mode          = mode_next;
    result.line          = line_next;
    result.coincidence   = (line_reg == cfg.compare_line);
    result.render_strobe = render;
    result.vblank_irq    = vblank;
    result.stat_irq      = stat;
  end

endmodule

// ===== src/lcd_mode_scanline_timer.sv =====
// top level of the lcd mode and scanline timer
//
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   elapsed[7:0]
// result    out        out_valid / out_ready mode[1:0] line[7:0] coincidence
//                                            render_strobe vblank_irq stat_irq
// config    in         apb psel/penable      paddr[4:0] pwdata[31:0] prdata[31:0]
//
// one item per cycle sustained while out_ready is high; results pass through
// (input register, then the state update and result register)
// the dot counter, mode and line advance in the cycle an item leaves the input register
// rst is synchronous and active high; it clears timing state, config and valid flags
// a stalled result holds the output register; the input register keeps taking items
// as long as it is empty or the result register is empty or drains in the same cycle
module lcd_mode_scanline_timer (
  input  logic                          clk,
  input  logic                          rst,
  // input item
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lmst_pkg::ELAP_W-1:0]   elapsed,
  // result item
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    mode,
  output logic [lmst_pkg::LINE_W-1:0]   line,
  output logic                          coincidence,
  output logic                          render_strobe,
  output logic                          vblank_irq,
  output logic                          stat_irq,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmst_pkg::PADDR_W-1:0]  paddr,
  input  logic [lmst_pkg::PDATA_W-1:0]  pwdata,
  output logic [lmst_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  lmst_pkg::cfg_t                cfg;
  lmst_pkg::result_t             result;
  lmst_pkg::result_t             out_reg;

  // input register
  logic                          s1_valid;
  logic [lmst_pkg::ELAP_W-1:0]   s1_elapsed;

  logic                          out_free;
  logic                          step_en;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  // the item in the input register is processed when its result has a place to go
  assign step_en  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  lmst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmst_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .elapsed (s1_elapsed),
    .cfg     (cfg),
    .result  (result)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (step_en) begin
        s1_valid <= 1'b0;
      end
      if (step_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_elapsed <= elapsed;
    end
    if (step_en) begin
      out_reg <= result;
    end
  end

  assign mode          = out_reg.mode;
  assign line          = out_reg.line;
  assign coincidence   = out_reg.coincidence;
  assign render_strobe = out_reg.render_strobe;
  assign vblank_irq    = out_reg.vblank_irq;
  assign stat_irq      = out_reg.stat_irq;

endmodule

// ===== dv/lcd_mode_scanline_timer_tb.sv =====
// self-checking testbench for the lcd mode and scanline timer
module lcd_mode_scanline_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmst_pkg::*;

  localparam int HOLD_CYCLES    = 64;    // long receiver hold-off, fills the pipeline
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either channel
  localparam int PHASE_ITEMS    = 90;    // items per configuration phase
  localparam int DRAIN_CYCLES   = 8;     // settle time after the last queued status is back

  // directed steps from reset: a zero step, the oam, transfer and hblank thresholds
  // each one dot short then met, then full-scale steps that saturate the dot counter
  localparam logic [ELAP_W-1:0] DIRECTED [22] = '{
    8'd0, 8'd1, 8'd203, 8'd79, 8'd1, 8'd171, 8'd1, 8'd203, 8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd128, 8'd64, 8'd2
  };

  // predicts the mode, line and interrupt status for each step and checks results
  class line_timer_scoreboard;
    cfg_t              cfg;
    logic [1:0]        cur_mode;
    logic [LINE_W-1:0] cur_line;
    logic [DOT_W-1:0]  dots;
    result_t           status_q[$];
    int fails, checked, vblank_count, wrap_count, saturate_count, match_irq_count;
    int render_count;

    function new();
      cfg      = '0;
      cur_mode = MODE_HBLANK;
      cur_line = '0;
      dots     = '0;
    endfunction

    function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
      case (idx)
        REG_DISPLAY_ENABLE:    cfg.display_enable    = value[0];
        REG_COMPARE_LINE:      cfg.compare_line      = value[LINE_W-1:0];
        REG_HBLANK_INT_ENABLE: cfg.hblank_int_enable = value[0];
        REG_VBLANK_INT_ENABLE: cfg.vblank_int_enable = value[0];
        REG_OAM_INT_ENABLE:    cfg.oam_int_enable    = value[0];
        REG_MATCH_INT_ENABLE:  cfg.match_int_enable  = value[0];
        default: ;
      endcase
    endfunction

    // advance the timing state by one step and queue the status it yields
    function void note_elapsed(input logic [ELAP_W-1:0] step);
      result_t r;
      int      sum;
      r = '0;
      r.coincidence = (cur_line == cfg.compare_line);
      sum = int'(dots) + int'(step);
      if (sum > int'(DOT_MAX)) begin
        sum = int'(DOT_MAX);
        saturate_count++;
      end
      dots = DOT_W'(sum);
      case (cur_mode)
        MODE_OAM: begin
          if (dots >= LEN_OAM) begin
            cur_mode = MODE_XFER;
            dots -= LEN_OAM;
          end
        end
        MODE_XFER: begin
          if (dots >= LEN_XFER) begin
            cur_mode        = MODE_HBLANK;
            r.render_strobe = cfg.display_enable;
            r.stat_irq      = cfg.hblank_int_enable;
            dots -= LEN_XFER;
          end
        end
        MODE_HBLANK: begin
          if (dots >= LEN_HBLANK) begin
            cur_line = cur_line + 1'b1;
            if (cur_line == FIRST_VBLANK_LINE) begin
              cur_mode     = MODE_VBLANK;
              r.vblank_irq = 1'b1;
              r.stat_irq   = cfg.vblank_int_enable;
              vblank_count++;
            end else begin
              cur_mode   = MODE_OAM;
              r.stat_irq = cfg.oam_int_enable;
              if (cfg.match_int_enable && cur_line == cfg.compare_line) begin
                r.stat_irq = 1'b1;
                match_irq_count++;
              end
            end
            dots -= LEN_HBLANK;
          end
        end
        default: begin
          if (dots >= LEN_LINE) begin
            cur_line = cur_line + 1'b1;
            if (cur_line > LAST_LINE) begin
              cur_mode = MODE_OAM;
              cur_line = '0;
              wrap_count++;
            end
            dots -= LEN_LINE;
          end
        end
      endcase
      r.mode = cur_mode;
      r.line = cur_line;
      if (r.render_strobe) render_count++;
      status_q.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (status_q.size() == 0) begin
        $error("result with no item outstanding: mode %0d line %0d", got.mode, got.line);
        fails++;
        return;
      end
      want = status_q.pop_front();
      checked++;
      compare_field("mode",          8'(want.mode),          8'(got.mode));
      compare_field("line",          want.line,              got.line);
      compare_field("coincidence",   8'(want.coincidence),   8'(got.coincidence));
      compare_field("render_strobe", 8'(want.render_strobe), 8'(got.render_strobe));
      compare_field("vblank_irq",    8'(want.vblank_irq),    8'(got.vblank_irq));
      compare_field("stat_irq",      8'(want.stat_irq),      8'(got.stat_irq));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [ELAP_W-1:0]   elapsed;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          mode;
  logic [LINE_W-1:0]   line;
  logic                coincidence;
  logic                render_strobe;
  logic                vblank_irq;
  logic                stat_irq;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  line_timer_scoreboard sb = new;
  int  idle_cycles;
  bit  quiet;     // no idling on either side in the last phase
  bit  hold_req;  // asks the receiver for one long hold-off

  lcd_mode_scanline_timer dut (
    .clk, .rst,
    .in_valid, .in_ready, .elapsed,
    .out_valid, .out_ready, .mode, .line, .coincidence,
    .render_strobe, .vblank_irq, .stat_irq,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // sample both channels at the rising edge; results are checked before the new
  // item is noted so a stray result can never be matched by its own item
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {mode, line, coincidence, render_strobe, vblank_irq, stat_irq};
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_elapsed(elapsed);
      idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : idle_cycles + 1;
    end
  end

  // hang detection: nothing moving on either channel for too long
  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("lcd_mode_scanline_timer_tb: FAIL");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request, none when quiet
  initial begin : sink
    out_ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // apb write then read back; called at a falling edge, returns at one
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rdata;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    // read setup, same address
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rdata !== value) begin
      $error("register %0d readback: expected %0h, got %0h", idx, value, rdata);
      sb.fails++;
    end
    sb.set_reg(idx, value);
  endtask

  task automatic apply_config(input cfg_t c);
    reg_write(REG_DISPLAY_ENABLE,    PDATA_W'(c.display_enable));
    reg_write(REG_COMPARE_LINE,      PDATA_W'(c.compare_line));
    reg_write(REG_HBLANK_INT_ENABLE, PDATA_W'(c.hblank_int_enable));
    reg_write(REG_VBLANK_INT_ENABLE, PDATA_W'(c.vblank_int_enable));
    reg_write(REG_OAM_INT_ENABLE,    PDATA_W'(c.oam_int_enable));
    reg_write(REG_MATCH_INT_ENABLE,  PDATA_W'(c.match_int_enable));
  endtask

  // sender goes quiet until every queued status has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.status_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one item, with an optional random gap in front; called and returns at a falling edge
  task automatic send_item(input logic [ELAP_W-1:0] value);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    elapsed  = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly large steps so whole frames go by, some small and some fully random
  function automatic logic [ELAP_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return ELAP_W'($urandom_range(0, 255));
      1:       return ELAP_W'($urandom_range(0, 15));
      default: return ELAP_W'($urandom_range(160, 255));
    endcase
  endfunction

  // compare line a few lines ahead of the predicted scanline so a match comes soon
  function automatic logic [LINE_W-1:0] line_ahead();
    return LINE_W'((int'(sb.cur_line) + $urandom_range(1, 3)) % (int'(LAST_LINE) + 1));
  endfunction

  initial begin : stimulus
    cfg_t c;
    rst      = 1'b1;
    in_valid = 1'b0;
    elapsed  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // everything on, compare against line 0 where the block starts
    c = '{display_enable: 1'b1, compare_line: 8'd0, hblank_int_enable: 1'b1,
          vblank_int_enable: 1'b1, oam_int_enable: 1'b1, match_int_enable: 1'b1};
    apply_config(c);
    foreach (DIRECTED[k]) send_item(DIRECTED[k]);
    repeat (PHASE_ITEMS - $size(DIRECTED)) send_item(pick_elapsed());

    // all off, compare line at its top value which no scanline reaches
    wait_drained();
    c = '{display_enable: 1'b0, compare_line: 8'd255, hblank_int_enable: 1'b0,
          vblank_int_enable: 1'b0, oam_int_enable: 1'b0, match_int_enable: 1'b0};
    apply_config(c);
    repeat (PHASE_ITEMS) send_item(pick_elapsed());

    // match source alone with hblank, and a long result stall while items keep coming
    wait_drained();
    c = '{display_enable: 1'b1, compare_line: line_ahead(), hblank_int_enable: 1'b1,
          vblank_int_enable: 1'b0, oam_int_enable: 1'b0, match_int_enable: 1'b1};
    apply_config(c);
    hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_item(pick_elapsed());

    // vblank and oam sources with match
    wait_drained();
    c = '{display_enable: 1'b1, compare_line: line_ahead(), hblank_int_enable: 1'b0,
          vblank_int_enable: 1'b1, oam_int_enable: 1'b1, match_int_enable: 1'b1};
    apply_config(c);
    repeat (PHASE_ITEMS) send_item(pick_elapsed());

    // last phase: random enables, both sides run without idling
    wait_drained();
    c = '{display_enable: 1'($urandom), compare_line: line_ahead(),
          hblank_int_enable: 1'($urandom), vblank_int_enable: 1'($urandom),
          oam_int_enable: 1'($urandom), match_int_enable: 1'($urandom)};
    apply_config(c);
    quiet = 1'b1;
    repeat (PHASE_ITEMS) send_item(pick_elapsed());

    wait_drained();
    $display("covered %0d steps over 5 register settings, %0d saturated, %0d frame wraps",
             sb.checked, sb.saturate_count, sb.wrap_count);
    $display("vblank entries %0d, render strobes %0d, line-match stat requests %0d",
             sb.vblank_count, sb.render_count, sb.match_irq_count);
    if (sb.fails == 0) begin
      $display("lcd_mode_scanline_timer_tb: PASS");
    end else begin
      $display("lcd_mode_scanline_timer_tb: FAIL");
    end
    $finish;
  end

endmodule
